[src/fdr_pkg.sv]
package fdr_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 24;
  localparam int unsigned D1W       = 33;
  localparam int unsigned D2W       = 49;

  // data that rides along the square root chain
  typedef struct packed {
    logic        tir;
    logic [16:0] cu;
    logic [15:0] q;
    logic [31:0] psq;
  } sq_side_t;

  // data that rides along the divider chain
  typedef struct packed {
    logic tir;
    logic eq1;
    logic eq2;
  } dv_side_t;

endpackage

[src/fdr_sqrt_cell.sv]
module fdr_sqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fdr_pkg::sq_side_t side_i,
  input  logic [63:0]       rad_i,
  input  logic [33:0]       rem_i,
  input  logic [31:0]       root_i,
  output logic              valid_o,
  output fdr_pkg::sq_side_t side_o,
  output logic [63:0]       rad_o,
  output logic [33:0]       rem_o,
  output logic [31:0]       root_o
);

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] rem_n;

  // one root bit per cell: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh = {rem_i, rad_i[63:62]};
    trial  = {2'b00, root_i, 2'b01};
    ge     = rem_sh >= trial;
    rem_n  = ge ? rem_sh - trial : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      rad_o  <= {rad_i[61:0], 2'b00};
      rem_o  <= rem_n[33:0];
      root_o <= {root_i[30:0], ge};
    end
  end

endmodule

[src/fdr_div_cell.sv]
module fdr_div_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  fdr_pkg::dv_side_t        side_i,
  input  logic [fdr_pkg::D1W-1:0]  d1_i,
  input  logic [fdr_pkg::D1W-1:0]  rem1_i,
  input  logic [23:0]              quo1_i,
  input  logic [fdr_pkg::D2W-1:0]  d2_i,
  input  logic [fdr_pkg::D2W-1:0]  rem2_i,
  input  logic [23:0]              quo2_i,
  output logic                     valid_o,
  output fdr_pkg::dv_side_t        side_o,
  output logic [fdr_pkg::D1W-1:0]  d1_o,
  output logic [fdr_pkg::D1W-1:0]  rem1_o,
  output logic [23:0]              quo1_o,
  output logic [fdr_pkg::D2W-1:0]  d2_o,
  output logic [fdr_pkg::D2W-1:0]  rem2_o,
  output logic [23:0]              quo2_o
);

  logic [fdr_pkg::D1W:0] sh1;
  logic [fdr_pkg::D2W:0] sh2;
  logic                  ge1;
  logic                  ge2;
  logic [fdr_pkg::D1W:0] r1_n;
  logic [fdr_pkg::D2W:0] r2_n;

  // one restoring quotient bit per lane
  always_comb begin
    sh1  = {rem1_i, 1'b0};
    sh2  = {rem2_i, 1'b0};
    ge1  = sh1 >= {1'b0, d1_i};
    ge2  = sh2 >= {1'b0, d2_i};
    r1_n = ge1 ? sh1 - {1'b0, d1_i} : sh1;
    r2_n = ge2 ? sh2 - {1'b0, d2_i} : sh2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      d1_o   <= d1_i;
      d2_o   <= d2_i;
      rem1_o <= r1_n[fdr_pkg::D1W-1:0];
      rem2_o <= r2_n[fdr_pkg::D2W-1:0];
      quo1_o <= {quo1_i[22:0], ge1};
      quo2_o <= {quo2_i[22:0], ge2};
    end
  end

endmodule

[src/fresnel_dielectric_reflectance_core.sv]
// Unpolarized Fresnel reflectance at a dielectric boundary.
// Input channel: cos_incident_i (signed, ANGLE_FRAC_BITS fraction bits) and
// relative_ior_i (unsigned Q4.12), taken when in_valid_i && in_ready_o.
// Output channel: reflectance_o (Q1.16, 65536 = 1.0) and total_internal_o,
// delivered when out_valid_o && out_ready_i. One result per item, in order.
// The block is a single pipeline: a few front stages for the squares and the
// total internal reflection test, a chain of 32 square root cells (one root
// bit each), stages for the products, numerators and denominators, a chain of
// 24 divider cells (one quotient bit each for both amplitude ratios) and two
// back stages for the squares and rounding. Throughput is one item per
// cycle, set by every cell taking a new item each cycle unless stalled.
// The output register holds the finished item; while the receiver stalls
// with a result waiting, the whole pipeline holds and in_ready_o drops, and
// it picks up again in the cycle out_ready_i returns. Items already inside
// are kept. Reset clears all valid bits; the pipeline starts empty and
// accepts an item in the first cycle after reset.
module fresnel_dielectric_reflectance_core #(
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] cos_incident_i,
  input  logic [15:0] relative_ior_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] reflectance_o,
  output logic        total_internal_o
);

  localparam int LSH = (ANGLE_FRAC_BITS <= 16) ? 16 - ANGLE_FRAC_BITS : 0;
  localparam int RSH = (ANGLE_FRAC_BITS > 16) ? ANGLE_FRAC_BITS - 16 : 0;
  localparam int NS  = fdr_pkg::SqrtSteps;
  localparam int ND  = fdr_pkg::DivSteps;
  localparam int D1W = fdr_pkg::D1W;
  localparam int D2W = fdr_pkg::D2W;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 0: clamp, direction, cosine to Q.16
  logic signed [31:0] c_ext;
  logic signed [31:0] one_s;
  logic signed [31:0] c_cl;
  logic [31:0]        cm;
  logic [31:0]        cu_w;
  logic               v0_q, tir0_q;
  logic [16:0]        cu0_q;
  logic [15:0]        p0_q, q0_q;

  always_comb begin
    c_ext = 32'(signed'(cos_incident_i));
    one_s = 32'sd1 <<< ANGLE_FRAC_BITS;
    c_cl  = c_ext;
    if (c_ext > one_s) c_cl = one_s;
    if (c_ext < -one_s) c_cl = -one_s;
    cm   = (c_cl < 0) ? 32'(-c_cl) : 32'(c_cl);
    cu_w = (cm << LSH) >> RSH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tir0_q <= relative_ior_i == 16'd0;
      cu0_q  <= (cu_w > 32'd65536) ? 17'h10000 : cu_w[16:0];
      p0_q   <= (c_cl < 0) ? 16'd4096 : relative_ior_i;
      q0_q   <= (c_cl < 0) ? relative_ior_i : 16'd4096;
    end
  end

  // stage 1: squares
  logic        v1_q, tir1_q;
  logic [16:0] cu1_q;
  logic [15:0] q1_q;
  logic [32:0] cusq1_q;
  logic [31:0] psq1_q, qsq1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tir1_q  <= tir0_q;
      cu1_q   <= cu0_q;
      q1_q    <= q0_q;
      cusq1_q <= 33'(34'(cu0_q) * 34'(cu0_q));
      psq1_q  <= 32'(p0_q) * 32'(p0_q);
      qsq1_q  <= 32'(q0_q) * 32'(q0_q);
    end
  end

  // stage 2: sin^2 * q^2 against p^2 * 2^32
  logic [32:0] s2;
  logic [63:0] lhs_c;
  logic        v2_q, tir2_q;
  logic [16:0] cu2_q;
  logic [15:0] q2_q;
  logic [31:0] psq2_q;
  logic [63:0] lhs2_q, rhs2_q;

  always_comb begin
    s2    = 33'h1_0000_0000 - cusq1_q;
    lhs_c = 64'(s2[31:0]) * 64'(qsq1_q) + (s2[32] ? {qsq1_q, 32'h0} : 64'h0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tir2_q <= tir1_q;
      cu2_q  <= cu1_q;
      q2_q   <= q1_q;
      psq2_q <= psq1_q;
      lhs2_q <= lhs_c;
      rhs2_q <= {psq1_q, 32'h0};
    end
  end

  // stage 3: test and radicand
  logic              v3_q;
  fdr_pkg::sq_side_t side3_q;
  logic [63:0]       diff3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q.tir <= tir2_q || (lhs2_q >= rhs2_q);
      side3_q.cu  <= cu2_q;
      side3_q.q   <= q2_q;
      side3_q.psq <= psq2_q;
      diff3_q     <= rhs2_q - lhs2_q;
    end
  end

  // square root chain
  logic              sv   [NS+1];
  fdr_pkg::sq_side_t sside[NS+1];
  logic [63:0]       srad [NS+1];
  logic [33:0]       srem [NS+1];
  logic [31:0]       sroot[NS+1];

  assign sv[0]    = v3_q;
  assign sside[0] = side3_q;
  assign srad[0]  = diff3_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    fdr_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sv[i]),
      .side_i (sside[i]),
      .rad_i  (srad[i]),
      .rem_i  (srem[i]),
      .root_i (sroot[i]),
      .valid_o(sv[i+1]),
      .side_o (sside[i+1]),
      .rad_o  (srad[i+1]),
      .rem_o  (srem[i+1]),
      .root_o (sroot[i+1])
    );
  end

  // stage 4: products
  logic        v4_q, tir4_q;
  logic [31:0] w4_q, qcu4_q;
  logic [47:0] pcu4_q, qw4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= sv[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tir4_q <= sside[NS].tir;
      w4_q   <= sroot[NS];
      qcu4_q <= 32'(33'(sside[NS].q) * 33'(sside[NS].cu));
      pcu4_q <= 48'(49'(sside[NS].psq) * 49'(sside[NS].cu));
      qw4_q  <= 48'(sside[NS].q) * 48'(sroot[NS]);
    end
  end

  // stage 5: numerators and denominators
  logic [D1W-1:0]    n1_c, d1_c;
  logic [D2W-1:0]    n2_c, d2_c;
  logic              v5_q;
  fdr_pkg::dv_side_t side5_q;
  logic [D1W-1:0]    n1_q, d1_q;
  logic [D2W-1:0]    n2_q, d2_q;

  always_comb begin
    n1_c = (qcu4_q > w4_q) ? D1W'(qcu4_q - w4_q) : D1W'(w4_q - qcu4_q);
    d1_c = D1W'(qcu4_q) + D1W'(w4_q);
    n2_c = (pcu4_q > qw4_q) ? D2W'(pcu4_q - qw4_q) : D2W'(qw4_q - pcu4_q);
    d2_c = D2W'(pcu4_q) + D2W'(qw4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q.tir <= tir4_q;
      side5_q.eq1 <= n1_c >= d1_c;
      side5_q.eq2 <= n2_c >= d2_c;
      n1_q        <= n1_c;
      d1_q        <= d1_c;
      n2_q        <= n2_c;
      d2_q        <= d2_c;
    end
  end

  // divider chain, both ratios side by side
  logic              dv   [ND+1];
  fdr_pkg::dv_side_t dside[ND+1];
  logic [D1W-1:0]    dd1  [ND+1];
  logic [D1W-1:0]    drem1[ND+1];
  logic [23:0]       dquo1[ND+1];
  logic [D2W-1:0]    dd2  [ND+1];
  logic [D2W-1:0]    drem2[ND+1];
  logic [23:0]       dquo2[ND+1];

  assign dv[0]    = v5_q;
  assign dside[0] = side5_q;
  assign dd1[0]   = d1_q;
  assign drem1[0] = n1_q;
  assign dquo1[0] = '0;
  assign dd2[0]   = d2_q;
  assign drem2[0] = n2_q;
  assign dquo2[0] = '0;

  for (genvar j = 0; j < ND; j++) begin : g_div
    fdr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(dv[j]),
      .side_i (dside[j]),
      .d1_i   (dd1[j]),
      .rem1_i (drem1[j]),
      .quo1_i (dquo1[j]),
      .d2_i   (dd2[j]),
      .rem2_i (drem2[j]),
      .quo2_i (dquo2[j]),
      .valid_o(dv[j+1]),
      .side_o (dside[j+1]),
      .d1_o   (dd1[j+1]),
      .rem1_o (drem1[j+1]),
      .quo1_o (dquo1[j+1]),
      .d2_o   (dd2[j+1]),
      .rem2_o (drem2[j+1]),
      .quo2_o (dquo2[j+1])
    );
  end

  // stage 6: squared ratios
  logic [24:0] r1, r2;
  logic        v6_q, tir6_q;
  logic [49:0] sq1_q, sq2_q;

  always_comb begin
    r1 = dside[ND].eq1 ? 25'h100_0000 : {1'b0, dquo1[ND]};
    r2 = dside[ND].eq2 ? 25'h100_0000 : {1'b0, dquo2[ND]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= dv[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tir6_q <= dside[ND].tir;
      sq1_q  <= 50'(r1) * 50'(r1);
      sq2_q  <= 50'(r2) * 50'(r2);
    end
  end

  // stage 7: mean, round half up, saturate; this is the output register
  logic [50:0] sum;
  logic [17:0] rnd;
  logic        out_v_q;
  logic [16:0] refl_q;
  logic        tir_q;

  always_comb begin
    sum = 51'(sq1_q) + 51'(sq2_q) + 51'h1_0000_0000;
    rnd = sum[50:33];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tir_q  <= tir6_q;
      refl_q <= (tir6_q || rnd > 18'd65536) ? 17'h10000 : rnd[16:0];
    end
  end

  assign out_valid_o      = out_v_q;
  assign reflectance_o    = refl_q;
  assign total_internal_o = tir_q;

  a_tir_is_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_internal_o |-> reflectance_o == 17'h10000)
    else $error("total internal reflection without full reflectance");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reflectance_o <= 17'h10000)
    else $error("reflectance above one");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reflectance_o))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (out_ready_i || !out_valid_o))
    else $error("pipeline enable mismatch");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int AngleFracBits = 14;
  localparam int NumRandom     = 1350;
  localparam int DrainCycles   = 80;

  typedef struct {
    logic [15:0] cos_val;
    logic [15:0] ior_val;
    bit          has_fixed;
    logic [16:0] fixed_refl;
    logic        fixed_tir;
  } stim_row_t;

  typedef struct {
    logic [16:0] refl;
    logic        tir;
  } fresnel_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] cos_incident_i = '0;
  logic [15:0] relative_ior_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [16:0] reflectance_o;
  logic        total_internal_o;

  fresnel_res_t pending_refl_q[$];
  int  error_count = 0;
  int  result_count = 0;
  int  tir_count = 0;
  bit  no_idle = 1'b0;

  always #5 clk_i = ~clk_i;

  fresnel_dielectric_reflectance_core #(
    .ANGLE_FRAC_BITS(AngleFracBits)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cos_incident_i  (cos_incident_i),
    .relative_ior_i  (relative_ior_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .reflectance_o   (reflectance_o),
    .total_internal_o(total_internal_o)
  );

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // floor(n * 2^24 / d), saturating at one
  function automatic logic [63:0] amp_ratio(logic [63:0] n, logic [63:0] d);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = n;
    if (rem >= d) return 64'd1 << 24;
    for (int i = 0; i < 24; i++) begin
      rem <<= 1;
      quo <<= 1;
      if (rem >= d) begin
        rem -= d;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic fresnel_res_t fresnel_reflectance(logic [15:0] cos_raw,
                                                       logic [15:0] ior);
    fresnel_res_t r;
    longint c;
    longint one;
    logic [63:0] p, q, cm, cu, s2, lhs, rhs, w, qc, ppc, qw;
    logic [63:0] r1, r2, sum;
    one = longint'(1) << AngleFracBits;
    c = longint'($signed(cos_raw));
    if (c > one) c = one;
    if (c < -one) c = -one;
    r.refl = 17'd65536;
    r.tir = 1'b1;
    if (ior == 0) return r;
    if (c < 0) begin
      p = 4096;
      q = ior;
      cm = -c;
    end else begin
      p = ior;
      q = 4096;
      cm = c;
    end
    if (AngleFracBits <= 16) cu = cm << (16 - AngleFracBits);
    else cu = cm >> (AngleFracBits - 16);
    if (cu > 65536) cu = 65536;
    s2 = (64'd1 << 32) - cu * cu;
    lhs = s2 * (q * q);
    rhs = (p * p) << 32;
    if (lhs >= rhs) return r;
    w = int_sqrt(rhs - lhs);
    qc = q * cu;
    ppc = p * p * cu;
    qw = q * w;
    r1 = amp_ratio((qc > w) ? qc - w : w - qc, qc + w);
    r2 = amp_ratio((ppc > qw) ? ppc - qw : qw - ppc, ppc + qw);
    sum = r1 * r1 + r2 * r2;
    sum = (sum + (64'd1 << 32)) >> 33;
    r.refl = (sum > 65536) ? 17'd65536 : sum[16:0];
    r.tir = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: MISMATCH %s", $realtime, msg);
    error_count++;
  endtask

  // one item through the input channel, with optional idle burst first
  task automatic send_item(stim_row_t row);
    fresnel_res_t exp_res;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    exp_res = fresnel_reflectance(row.cos_val, row.ior_val);
    if (row.has_fixed && (exp_res.refl != row.fixed_refl || exp_res.tir != row.fixed_tir))
      report_mismatch($sformatf("table row cos=%h ior=%h disagrees with prediction",
                                row.cos_val, row.ior_val));
    if (row.has_fixed) begin
      exp_res.refl = row.fixed_refl;
      exp_res.tir = row.fixed_tir;
    end
    pending_refl_q.push_back(exp_res);
    in_valid_i <= 1'b1;
    cos_incident_i <= row.cos_val;
    relative_ior_i <= row.ior_val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver side: random stall bursts, stops idling near the end
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    fresnel_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_refl_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        exp_res = pending_refl_q.pop_front();
        if (total_internal_o) tir_count++;
        if (reflectance_o !== exp_res.refl)
          report_mismatch($sformatf("reflectance %0d, expected %0d",
                                    reflectance_o, exp_res.refl));
        if (total_internal_o !== exp_res.tir)
          report_mismatch($sformatf("total_internal %b, expected %b",
                                    total_internal_o, exp_res.tir));
      end
    end
  end

  initial begin
    stim_row_t directed_rows[$];
    stim_row_t row;
    int cls;
    directed_rows = '{
      '{16'h4000, 16'h0000, 1'b1, 17'd65536, 1'b1},  // zero index
      '{16'h8000, 16'h0000, 1'b1, 17'd65536, 1'b1},
      '{16'h4000, 16'h1000, 1'b1, 17'd0, 1'b0},      // matched index
      '{16'hC000, 16'h1000, 1'b1, 17'd0, 1'b0},
      '{16'h7FFF, 16'h1800, 1'b0, 17'd0, 1'b0},      // clamped above one
      '{16'h8000, 16'h1800, 1'b0, 17'd0, 1'b0},      // clamped below minus one
      '{16'h0000, 16'h1800, 1'b0, 17'd0, 1'b0},      // grazing
      '{16'h0000, 16'h0800, 1'b1, 17'd65536, 1'b1},  // grazing from dense side
      '{16'hFFFF, 16'h1800, 1'b0, 17'd0, 1'b0},      // tiny negative, inside
      '{16'h0001, 16'h0800, 1'b0, 17'd0, 1'b0},
      '{16'h2000, 16'h0800, 1'b0, 17'd0, 1'b0},
      '{16'hE000, 16'h1800, 1'b0, 17'd0, 1'b0},
      '{16'h4000, 16'hFFFF, 1'b0, 17'd0, 1'b0},      // index extremes
      '{16'hC000, 16'hFFFF, 1'b0, 17'd0, 1'b0},
      '{16'h4000, 16'h0001, 1'b0, 17'd0, 1'b0},
      '{16'hC000, 16'h0001, 1'b0, 17'd0, 1'b0},
      '{16'h0001, 16'hFFFF, 1'b0, 17'd0, 1'b0},
      '{16'h1000, 16'h1555, 1'b0, 17'd0, 1'b0},
      '{16'hF000, 16'h1555, 1'b0, 17'd0, 1'b0},
      '{16'h5555, 16'hAAAA, 1'b0, 17'd0, 1'b0},
      '{16'hAAAA, 16'h5555, 1'b0, 17'd0, 1'b0}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 150) no_idle = 1'b1;
      cls = $urandom_range(0, 9);
      row.has_fixed = 1'b0;
      row.fixed_refl = '0;
      row.fixed_tir = 1'b0;
      // mostly in-range cosines and physical indices, some full-range noise
      if (cls < 4) row.cos_val = 16'($urandom_range(0, 32768) - 16384);
      else if (cls < 6) row.cos_val = 16'($urandom_range(0, 2048) - 1024);
      else row.cos_val = 16'($urandom);
      if (cls == 9) row.ior_val = 16'($urandom);
      else if (cls == 8) row.ior_val = 16'($urandom_range(0, 3));
      else row.ior_val = 16'($urandom_range(2048, 12288));
      send_item(row);
    end
    in_valid_i <= 1'b0;
    fork
      begin
        wait (pending_refl_q.size() == 0);
        repeat (DrainCycles) @(posedge clk_i);
      end
      begin
        repeat (20000) @(posedge clk_i);
        report_mismatch("results still outstanding at end");
      end
    join_any
    $display("Ran %0d items (%0d directed), %0d results, %0d total internal reflections.",
             directed_rows.size() + NumRandom, directed_rows.size(), result_count, tir_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout waiting for handshakes");
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
src/fdr_pkg.sv
src/fdr_sqrt_cell.sv
src/fdr_div_cell.sv
src/fresnel_dielectric_reflectance_core.sv
sim/testbench.sv
